FILE: sv/ray_triangle_intersect_top_macros.svh
// Assertion macros shared by the ray/triangle intersection RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef RAY_TRIANGLE_INTERSECT_TOP_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RTI_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rti assertion failed");

// Next-cycle implication, disabled during reset.
`define RTI_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rti assertion failed");

`endif

FILE: sv/rti_pkg.sv
// Shared types and constants for the ray/triangle intersection block.
// Depends on nothing; every other RTL file refers to it by scoped names.
`default_nettype none

package rti_pkg;

   localparam int CORD_W  = 32;  // vertex and origin coordinates, Q16.16
   localparam int DIR_W   = 18;  // direction components
   localparam int SLACK_W = 17;  // edge tolerance
   localparam int FRAC_W  = 16;
   localparam int EDGE_W  = CORD_W + 1;

   // Split multiplier operand and product widths.
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 88;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int PP_W    = MUL_A_W + 33;
   localparam int PPH_W   = MUL_A_W + MUL_B_W - 64;

   localparam int P_W    = 52;   // d x e2 components
   localparam int Q_W    = 67;   // s x e1 components
   localparam int DOT_W  = 88;   // det, s.p and d.q
   localparam int NT_W   = 101;  // e2.q
   localparam int CMP_W  = 106;  // bound comparisons
   localparam int MAG_W  = 117;  // |e2.q| scaled by one
   localparam int DEN_W  = 85;   // |det|
   localparam int DIV_W  = 120;  // divider remainder
   localparam int QUO_W  = 32;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_SLACK = 3'd6;

   localparam logic signed [DIR_W-1:0] DIR_X_RESET = 18'sd65536;
   localparam logic [QUO_W-1:0] RAW_POS_MAX = 32'h7fff_ffff;
   localparam logic [QUO_W-1:0] RAW_NEG_MAX = 32'h8000_0000;

   typedef struct packed {
      logic signed [CORD_W-1:0] vertex_a_x;
      logic signed [CORD_W-1:0] vertex_a_y;
      logic signed [CORD_W-1:0] vertex_a_z;
      logic signed [CORD_W-1:0] vertex_b_x;
      logic signed [CORD_W-1:0] vertex_b_y;
      logic signed [CORD_W-1:0] vertex_b_z;
      logic signed [CORD_W-1:0] vertex_c_x;
      logic signed [CORD_W-1:0] vertex_c_y;
      logic signed [CORD_W-1:0] vertex_c_z;
   } req_payload_type;

   typedef struct packed {
      logic                     hit;
      logic signed [CORD_W-1:0] ray_param;
   } rsp_payload_type;

   typedef struct packed {
      logic             vld;
      logic             hit;
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic [DEN_W-1:0] den;
   } div_in_type;

   typedef struct packed {
      logic vld;
      logic hit;
      logic neg;
      logic ovf;
   } div_ctl_type;

   typedef struct packed {
      logic             vld;
      logic             hit;
      logic             neg;
      logic             ovf;
      logic [QUO_W-1:0] quo;
   } div_out_type;

endpackage

`default_nettype wire

FILE: sv/rti_mul.sv
// Two-stage signed multiplier built from three partial products whose operands are at most 33 bits wide.
// Depends on rti_pkg for the operand and product widths.
`default_nettype none

module rti_mul (
   input  wire logic                                clock,
   input  wire logic                                en,
   input  wire logic signed [rti_pkg::MUL_A_W-1:0]  mul_a,
   input  wire logic signed [rti_pkg::MUL_B_W-1:0]  mul_b,
   output      logic signed [rti_pkg::MUL_P_W-1:0]  mul_p
);

   logic signed [rti_pkg::PP_W-1:0]    pp0_ff;
   logic signed [rti_pkg::PP_W-1:0]    pp1_ff;
   logic signed [rti_pkg::PPH_W-1:0]   pp2_ff;
   logic signed [rti_pkg::MUL_P_W-1:0] prod_ff;

   // The two low slices of the wide operand are unsigned; only the top slice carries the sign.
   always_ff @(posedge clock) begin
      if (en) begin
         pp0_ff  <= mul_a * $signed({1'b0, mul_b[31:0]});
         pp1_ff  <= mul_a * $signed({1'b0, mul_b[63:32]});
         pp2_ff  <= mul_a * $signed(mul_b[rti_pkg::MUL_B_W-1:64]);
         prod_ff <= rti_pkg::MUL_P_W'(pp0_ff)
                  + (rti_pkg::MUL_P_W'(pp1_ff) <<< 32)
                  + (rti_pkg::MUL_P_W'(pp2_ff) <<< 64);
      end
   end

   assign mul_p = prod_ff;

endmodule

`default_nettype wire

FILE: sv/rti_div.sv
// Pipelined restoring divider for the ray parameter: one quotient bit per stage.
// Depends on rti_pkg and on the shared assertion macro header.
`default_nettype none
`include "ray_triangle_intersect_top_macros.svh"

module rti_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire rti_pkg::div_in_type  div_in,
   output      rti_pkg::div_out_type div_out
);

   localparam int NSTG = rti_pkg::QUO_W;

   rti_pkg::div_ctl_type             ctl_ff [0:NSTG];
   logic [rti_pkg::DIV_W-1:0]        rem_ff [0:NSTG];
   logic [rti_pkg::DEN_W-1:0]        den_ff [0:NSTG];
   logic [rti_pkg::QUO_W-1:0]        quo_ff [0:NSTG];
   logic                             ovf_in;

   // A quotient of 2^32 or more saturates whatever its sign, so it is flagged up front.
   assign ovf_in = rti_pkg::DIV_W'(div_in.mag)
                   >= (rti_pkg::DIV_W'(div_in.den) << rti_pkg::QUO_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0] <= '{vld: div_in.vld, hit: div_in.hit, neg: div_in.neg, ovf: ovf_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rti_pkg::DIV_W'(div_in.mag);
         den_ff[0] <= div_in.den;
         quo_ff[0] <= '0;
      end
   end

   for (genvar gk = 1; gk <= NSTG; gk++) begin : g_stage
      localparam int BIT = NSTG - gk;
      logic [rti_pkg::DIV_W-1:0] sft;
      logic                      take;
      logic [rti_pkg::QUO_W-1:0] quo_in;
      logic [rti_pkg::DIV_W-1:0] rem_in;

      always_comb begin
         sft    = rti_pkg::DIV_W'(den_ff[gk-1]) << BIT;
         take   = rem_ff[gk-1] >= sft;
         rem_in = take ? rem_ff[gk-1] - sft : rem_ff[gk-1];
         quo_in = quo_ff[gk-1];
         quo_in[BIT] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[gk] <= '0;
         end else if (en) begin
            ctl_ff[gk] <= ctl_ff[gk-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[gk] <= rem_in;
            den_ff[gk] <= den_ff[gk-1];
            quo_ff[gk] <= quo_in;
         end
      end
   end

   assign div_out = '{vld: ctl_ff[NSTG].vld, hit: ctl_ff[NSTG].hit, neg: ctl_ff[NSTG].neg,
                      ovf: ctl_ff[NSTG].ovf, quo: quo_ff[NSTG]};

   `RTI_ASSERT_IMP(a_entry_below_limit, ctl_ff[0].vld && !ctl_ff[0].ovf, rem_ff[0] < (rti_pkg::DIV_W'(den_ff[0]) << rti_pkg::QUO_W))
   `RTI_ASSERT_IMP(a_final_rem_below_den, ctl_ff[NSTG].vld && ctl_ff[NSTG].hit && !ctl_ff[NSTG].ovf, rem_ff[NSTG] < rti_pkg::DIV_W'(den_ff[NSTG]))
   `RTI_ASSERT_NEXT(a_valid_moves, en, ctl_ff[1].vld == $past(ctl_ff[0].vld))

endmodule

`default_nettype wire

FILE: sv/ray_triangle_intersect_top.sv
// Channel | Direction | Handshake           | Content
// req     | in        | req_valid/req_stall | one triangle, three Q16.16 vertices
// rsp     | out       | rsp_valid/rsp_stall | hit flag and saturated ray parameter
// csr     | in        | csr_valid/csr_ready | ray origin, direction and edge tolerance
//
// One triangle is accepted every cycle while req_stall is low; its result is presented from the output register.
// The path holds 46 registers: 12 arithmetic stages, the divider's entry register, its 32
// quotient stages (one quotient bit a stage) and the output register.
// While a result waits under rsp_stall the whole pipeline holds and req_stall is raised.
// Synchronous reset clears the valid bits and loads the register reset values; no clearing pass.
// Top level of the ray/triangle intersection; uses rti_pkg, rti_mul, rti_div and the macro header.
`default_nettype none
`include "ray_triangle_intersect_top_macros.svh"

module ray_triangle_intersect_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire rti_pkg::req_payload_type          req_payload,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      rti_pkg::rsp_payload_type          rsp_payload,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [rti_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rti_pkg::CORD_W-1:0]        csr_wdata
);

   localparam int NVLD = 12;

   // Configuration registers.
   logic signed [rti_pkg::CORD_W-1:0]  origin_ff [3];
   logic signed [rti_pkg::DIR_W-1:0]   dir_ff [3];
   logic [rti_pkg::SLACK_W-1:0]        slack_ff;

   logic                               pipe_adv;
   logic [NVLD:1]                      vld_ff;

   logic signed [rti_pkg::CORD_W-1:0]  va [3];
   logic signed [rti_pkg::CORD_W-1:0]  vb [3];
   logic signed [rti_pkg::CORD_W-1:0]  vc [3];

   logic signed [rti_pkg::EDGE_W-1:0]  e1_ff [1:4][3];
   logic signed [rti_pkg::EDGE_W-1:0]  e2_ff [1:4][3];
   logic signed [rti_pkg::EDGE_W-1:0]  s_ff  [1:4][3];
   logic signed [rti_pkg::DIR_W-1:0]   d_ff  [1:4][3];

   logic signed [rti_pkg::MUL_P_W-1:0] m1_p [12];
   logic signed [rti_pkg::MUL_P_W-1:0] m2_p [12];
   logic signed [rti_pkg::MUL_P_W-1:0] sd_p;

   logic signed [rti_pkg::P_W-1:0]     p_ff [3];
   logic signed [rti_pkg::Q_W-1:0]     q_ff [3];

   logic signed [rti_pkg::DOT_W-1:0]   det7_ff, np7_ff, nq7_ff;
   logic signed [rti_pkg::NT_W-1:0]    nt7_ff;

   logic signed [rti_pkg::DOT_W-1:0]   det_ff [8:10];
   logic signed [rti_pkg::DOT_W-1:0]   np_ff  [8:10];
   logic signed [rti_pkg::DOT_W-1:0]   nq_ff  [8:10];
   logic signed [rti_pkg::NT_W-1:0]    nt_ff  [8:10];
   logic [10:8]                        detz_ff;

   logic signed [rti_pkg::CMP_W-1:0]   lo11_ff, hi11_ff, nu11_ff, nv11_ff, nuv11_ff;
   logic signed [rti_pkg::CMP_W-1:0]   sd_c, nu_c, nv_c;
   logic signed [rti_pkg::NT_W-1:0]    nt_abs;
   logic [rti_pkg::MAG_W-1:0]          mag11_ff, mag12_ff;
   logic [rti_pkg::DEN_W-1:0]          den11_ff, den12_ff;
   logic                               neg11_ff, neg12_ff, detz11_ff, hit12_ff;

   rti_pkg::div_in_type                div_in;
   rti_pkg::div_out_type               div_out;

   logic                               rsp_vld_ff;
   rti_pkg::rsp_payload_type           rsp_ff, rsp_in;

   // ---------------------------------------------------------------- configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '{default: '0};
         dir_ff    <= '{rti_pkg::DIR_X_RESET, '0, '0};
         slack_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rti_pkg::CSR_ORIGIN_X:   origin_ff[0] <= csr_wdata;
            rti_pkg::CSR_ORIGIN_Y:   origin_ff[1] <= csr_wdata;
            rti_pkg::CSR_ORIGIN_Z:   origin_ff[2] <= csr_wdata;
            rti_pkg::CSR_DIR_X:      dir_ff[0]    <= csr_wdata[rti_pkg::DIR_W-1:0];
            rti_pkg::CSR_DIR_Y:      dir_ff[1]    <= csr_wdata[rti_pkg::DIR_W-1:0];
            rti_pkg::CSR_DIR_Z:      dir_ff[2]    <= csr_wdata[rti_pkg::DIR_W-1:0];
            rti_pkg::CSR_EDGE_SLACK: slack_ff     <= csr_wdata[rti_pkg::SLACK_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   assign pipe_adv  = !(rsp_vld_ff && rsp_stall);
   assign req_stall = !pipe_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_adv) begin
         vld_ff <= {vld_ff[NVLD-1:1], req_valid};
      end
   end

   // ---------------------------------------------------------------- stage 1: edges
   always_comb begin
      va = '{req_payload.vertex_a_x, req_payload.vertex_a_y, req_payload.vertex_a_z};
      vb = '{req_payload.vertex_b_x, req_payload.vertex_b_y, req_payload.vertex_b_z};
      vc = '{req_payload.vertex_c_x, req_payload.vertex_c_y, req_payload.vertex_c_z};
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[1][i] <= rti_pkg::EDGE_W'(vb[i]) - rti_pkg::EDGE_W'(va[i]);
            e2_ff[1][i] <= rti_pkg::EDGE_W'(vc[i]) - rti_pkg::EDGE_W'(va[i]);
            s_ff[1][i]  <= rti_pkg::EDGE_W'(origin_ff[i]) - rti_pkg::EDGE_W'(va[i]);
            d_ff[1][i]  <= dir_ff[i];
         end
         for (int k = 2; k <= 4; k++) begin
            e1_ff[k] <= e1_ff[k-1];
            e2_ff[k] <= e2_ff[k-1];
            s_ff[k]  <= s_ff[k-1];
            d_ff[k]  <= d_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- stages 2-4: p = d x e2, q = s x e1
   for (genvar gi = 0; gi < 3; gi++) begin : g_cross
      localparam int J = (gi + 1) % 3;
      localparam int K = (gi + 2) % 3;
      rti_mul u_p_pos (.clock, .en(pipe_adv),
         .mul_a(rti_pkg::MUL_A_W'(d_ff[1][J])), .mul_b(rti_pkg::MUL_B_W'(e2_ff[1][K])),
         .mul_p(m1_p[4*gi]));
      rti_mul u_p_neg (.clock, .en(pipe_adv),
         .mul_a(rti_pkg::MUL_A_W'(d_ff[1][K])), .mul_b(rti_pkg::MUL_B_W'(e2_ff[1][J])),
         .mul_p(m1_p[4*gi+1]));
      rti_mul u_q_pos (.clock, .en(pipe_adv),
         .mul_a(s_ff[1][J]), .mul_b(rti_pkg::MUL_B_W'(e1_ff[1][K])),
         .mul_p(m1_p[4*gi+2]));
      rti_mul u_q_neg (.clock, .en(pipe_adv),
         .mul_a(s_ff[1][K]), .mul_b(rti_pkg::MUL_B_W'(e1_ff[1][J])),
         .mul_p(m1_p[4*gi+3]));
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= rti_pkg::P_W'(m1_p[4*i]) - rti_pkg::P_W'(m1_p[4*i+1]);
            q_ff[i] <= rti_pkg::Q_W'(m1_p[4*i+2]) - rti_pkg::Q_W'(m1_p[4*i+3]);
         end
      end
   end

   // ---------------------------------------------------------------- stages 5-7: dot products
   for (genvar gi = 0; gi < 3; gi++) begin : g_dot
      rti_mul u_det (.clock, .en(pipe_adv),
         .mul_a(e1_ff[4][gi]), .mul_b(rti_pkg::MUL_B_W'(p_ff[gi])), .mul_p(m2_p[4*gi]));
      rti_mul u_np (.clock, .en(pipe_adv),
         .mul_a(s_ff[4][gi]), .mul_b(rti_pkg::MUL_B_W'(p_ff[gi])), .mul_p(m2_p[4*gi+1]));
      rti_mul u_nq (.clock, .en(pipe_adv),
         .mul_a(rti_pkg::MUL_A_W'(d_ff[4][gi])), .mul_b(rti_pkg::MUL_B_W'(q_ff[gi])),
         .mul_p(m2_p[4*gi+2]));
      rti_mul u_nt (.clock, .en(pipe_adv),
         .mul_a(e2_ff[4][gi]), .mul_b(rti_pkg::MUL_B_W'(q_ff[gi])), .mul_p(m2_p[4*gi+3]));
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         det7_ff <= rti_pkg::DOT_W'(m2_p[0]) + rti_pkg::DOT_W'(m2_p[4])
                  + rti_pkg::DOT_W'(m2_p[8]);
         np7_ff  <= rti_pkg::DOT_W'(m2_p[1]) + rti_pkg::DOT_W'(m2_p[5])
                  + rti_pkg::DOT_W'(m2_p[9]);
         nq7_ff  <= rti_pkg::DOT_W'(m2_p[2]) + rti_pkg::DOT_W'(m2_p[6])
                  + rti_pkg::DOT_W'(m2_p[10]);
         nt7_ff  <= rti_pkg::NT_W'(m2_p[3]) + rti_pkg::NT_W'(m2_p[7])
                  + rti_pkg::NT_W'(m2_p[11]);
      end
   end

   // ---------------------------------------------------------------- stage 8: make det positive
   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         detz_ff[8] <= det7_ff == '0;
         if (det7_ff < 0) begin
            det_ff[8] <= -det7_ff;
            np_ff[8]  <= -np7_ff;
            nq_ff[8]  <= -nq7_ff;
            nt_ff[8]  <= -nt7_ff;
         end else begin
            det_ff[8] <= det7_ff;
            np_ff[8]  <= np7_ff;
            nq_ff[8]  <= nq7_ff;
            nt_ff[8]  <= nt7_ff;
         end
         for (int k = 9; k <= 10; k++) begin
            detz_ff[k] <= detz_ff[k-1];
            det_ff[k]  <= det_ff[k-1];
            np_ff[k]   <= np_ff[k-1];
            nq_ff[k]   <= nq_ff[k-1];
            nt_ff[k]   <= nt_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- stages 9-10: slack times det
   rti_mul u_slack (.clock, .en(pipe_adv),
      .mul_a($signed(rti_pkg::MUL_A_W'(slack_ff))), .mul_b(det_ff[8]), .mul_p(sd_p));

   // ---------------------------------------------------------------- stage 11: bounds
   always_comb begin
      sd_c   = rti_pkg::CMP_W'(sd_p);
      nu_c   = rti_pkg::CMP_W'(np_ff[10]) <<< rti_pkg::FRAC_W;
      nv_c   = rti_pkg::CMP_W'(nq_ff[10]) <<< rti_pkg::FRAC_W;
      nt_abs = nt_ff[10] < 0 ? -nt_ff[10] : nt_ff[10];
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         lo11_ff   <= -sd_c;
         // The upper bound is (slack + one) * det, with one = 2^16 in Q16.16.
         hi11_ff   <= sd_c + (rti_pkg::CMP_W'(det_ff[10]) <<< rti_pkg::FRAC_W);
         nu11_ff   <= nu_c;
         nv11_ff   <= nv_c;
         nuv11_ff  <= nu_c + nv_c;
         mag11_ff  <= rti_pkg::MAG_W'($unsigned(nt_abs)) << rti_pkg::FRAC_W;
         neg11_ff  <= nt_ff[10] < 0;
         den11_ff  <= rti_pkg::DEN_W'($unsigned(det_ff[10]));
         detz11_ff <= detz_ff[10];
      end
   end

   // ---------------------------------------------------------------- stage 12: hit test
   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         hit12_ff <= !detz11_ff && !(nu11_ff < lo11_ff || hi11_ff < nu11_ff
                                     || nv11_ff < lo11_ff || hi11_ff < nuv11_ff);
         mag12_ff <= mag11_ff;
         den12_ff <= den11_ff;
         neg12_ff <= neg11_ff;
      end
   end

   assign div_in = '{vld: vld_ff[NVLD], hit: hit12_ff, neg: neg12_ff,
                     mag: mag12_ff, den: den12_ff};

   rti_div u_div (.clock, .reset, .en(pipe_adv), .div_in, .div_out);

   // ---------------------------------------------------------------- output register
   always_comb begin
      rsp_in = '0;
      if (div_out.hit) begin
         rsp_in.hit = 1'b1;
         if (!div_out.neg) begin
            rsp_in.ray_param = (div_out.ovf || div_out.quo > rti_pkg::RAW_POS_MAX)
                               ? rti_pkg::RAW_POS_MAX : div_out.quo;
         end else begin
            rsp_in.ray_param = (div_out.ovf || div_out.quo > rti_pkg::RAW_NEG_MAX)
                               ? rti_pkg::RAW_NEG_MAX : -div_out.quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (pipe_adv) begin
         rsp_vld_ff <= div_out.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   `RTI_ASSERT_IMP(a_miss_has_zero_param, rsp_valid && !rsp_payload.hit, rsp_payload.ray_param == '0)
   `RTI_ASSERT_NEXT(a_accept_enters_pipe, req_valid && !req_stall, vld_ff[1])
   `RTI_ASSERT_NEXT(a_hold_keeps_valids, !pipe_adv, $stable(vld_ff) && rsp_valid)

endmodule

`default_nettype wire
